/* rtl/core/socks5_connect_handshake_unit_assert.svh */
// Assertion macros for the checker of this block.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef SOCKS5_CONNECT_HANDSHAKE_UNIT_ASSERT_SVH
`define SOCKS5_CONNECT_HANDSHAKE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define S5_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("socks5 handshake: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define S5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("socks5 handshake: next-cycle check failed");

`endif

/* rtl/core/socks5_hs_pkg.sv */
`default_nettype none

package socks5_hs_pkg;

  // request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // protocol bytes
  localparam logic [7:0] SOCKS_VER     = 8'h05;
  localparam logic [7:0] NMETHODS_ONE  = 8'h01;
  localparam logic [7:0] METHOD_NOAUTH = 8'h00;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] RSV_BYTE      = 8'h00;
  localparam logic [7:0] REP_SUCCESS   = 8'h00;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;

  localparam int unsigned CNT_W = 9;
  localparam int unsigned IDX_W = 4;

  // bytes left to skip after the address type: address plus 2 port bytes
  localparam logic [CNT_W-1:0] SKIP_IPV4 = CNT_W'(4 + 2);
  localparam logic [CNT_W-1:0] SKIP_IPV6 = CNT_W'(16 + 2);
  localparam logic [CNT_W-1:0] SKIP_PORT = CNT_W'(2);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_METHOD = 3'd1,
    PH_HEAD   = 3'd2,
    PH_DLEN   = 3'd3,
    PH_SKIP   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    BURST_GREET = 2'd0,
    BURST_REQ   = 2'd1,
    BURST_OK    = 2'd2,
    BURST_FAIL  = 2'd3
  } burst_e;

  // one group of results handed from control to the serialiser
  typedef struct packed {
    burst_e      kind;
    logic [31:0] addr;
    logic [15:0] port;
  } burst_t;

  function automatic logic [IDX_W-1:0] burst_last_idx(input burst_e kind);
    logic [IDX_W-1:0] idx;
    unique case (kind)
      BURST_GREET: idx = IDX_W'(2);
      BURST_REQ:   idx = IDX_W'(9);
      default:     idx = '0;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/socks5_hs_if.sv */
`default_nettype none

interface socks5_hs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  rx_byte;
  logic [31:0] target_addr;
  logic [15:0] target_port;

  modport source (output valid, req_type, rx_byte, target_addr, target_port, input ready);
  modport sink   (input valid, req_type, rx_byte, target_addr, target_port, output ready);
endinterface

interface socks5_hs_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, out_kind, tx_byte, last, input ready);
  modport sink   (input valid, out_kind, tx_byte, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/socks5_connect_handshake_unit.sv */
// Channel  | Dir | Transaction carries                          | Modport
// ---------+-----+---------------------------------------------+--------
// req_i    | in  | req_type, rx_byte, target_addr, target_port | sink
// res_o    | out | out_kind, tx_byte, last                     | source
//
// Cycles: an item with no result is taken every cycle; one with results waits
// until the previous group leaves res_o (greeting 3, request 10, status 1).
// Path: req_i -> input register -> result register -> res_o.
// Reset: rst_ni asynchronous, active low; block comes up idle, nothing held.
// Stalls: res_o back-pressure holds the result; an item with results then
// waits in the input register and req_i.ready drops.
`default_nettype none

module socks5_connect_handshake_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  socks5_hs_req_if.sink   req_i,
  socks5_hs_res_if.source res_o
);

  // group of results passed from the handshake FSM to the serialiser
  socks5_hs_pkg::burst_t burst;
  logic                  burst_valid;
  logic                  burst_ready;

  // input register, protocol FSM, saved target
  socks5_hs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .burst_o       (burst),
    .burst_valid_o (burst_valid),
    .burst_ready_i (burst_ready)
  );

  // result register: turns one group into single-byte transactions
  socks5_hs_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_i       (burst),
    .burst_valid_i (burst_valid),
    .burst_ready_o (burst_ready),
    .res_o         (res_o)
  );

endmodule

`default_nettype wire

/* rtl/core/socks5_hs_ctrl.sv */
`default_nettype none

module socks5_hs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  socks5_hs_req_if.sink         req_i,
  output socks5_hs_pkg::burst_t burst_o,
  output logic                  burst_valid_o,
  input  logic                  burst_ready_i
);

  localparam int unsigned CW = socks5_hs_pkg::CNT_W;

  // input register
  logic        in_valid_q;
  logic [1:0]  req_type_q;
  logic [7:0]  rx_byte_q;
  logic [31:0] addr_in_q;
  logic [15:0] port_in_q;

  // handshake state
  socks5_hs_pkg::phase_e phase_q, phase_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  hdr_ok_q, hdr_ok_d;
  logic [31:0]           saved_addr_q;
  logic [15:0]           saved_port_q;

  logic                  is_start, is_close, is_byte;
  logic [CW-1:0]         cnt_inc, cnt_dec;
  logic [7:0]            meth_want;
  logic                  meth_ok, meth_done, head_ok, head_done;
  logic                  has_burst, proc_fire;
  socks5_hs_pkg::burst_e burst_kind;

  assign proc_fire   = in_valid_q && (!has_burst || burst_ready_i);
  assign req_i.ready = !in_valid_q || proc_fire;

  always_comb begin
    is_start  = (req_type_q == socks5_hs_pkg::REQ_START);
    is_close  = (req_type_q == socks5_hs_pkg::REQ_CLOSE);
    is_byte   = (req_type_q == socks5_hs_pkg::REQ_BYTE) &&
                (phase_q != socks5_hs_pkg::PH_IDLE);
    cnt_inc   = cnt_q + CW'(1);
    cnt_dec   = (cnt_q != '0) ? cnt_q - CW'(1) : cnt_q;
    meth_want = (cnt_q == '0) ? socks5_hs_pkg::SOCKS_VER : socks5_hs_pkg::METHOD_NOAUTH;
    meth_ok   = hdr_ok_q && (rx_byte_q == meth_want);
    meth_done = (cnt_inc >= CW'(2));
    head_ok   = hdr_ok_q &&
                !((cnt_q == CW'(0)) && (rx_byte_q != socks5_hs_pkg::SOCKS_VER)) &&
                !((cnt_q == CW'(1)) && (rx_byte_q != socks5_hs_pkg::REP_SUCCESS));
    head_done = (cnt_q >= CW'(3));
  end

  // next state
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    hdr_ok_d = hdr_ok_q;
    if (is_start) begin
      phase_d  = socks5_hs_pkg::PH_METHOD;
      cnt_d    = '0;
      hdr_ok_d = 1'b1;
    end else if (is_close) begin
      phase_d  = socks5_hs_pkg::PH_IDLE;
      cnt_d    = '0;
      hdr_ok_d = 1'b1;
    end else if (is_byte) begin
      unique case (phase_q)
        socks5_hs_pkg::PH_METHOD: begin
          cnt_d    = cnt_inc;
          hdr_ok_d = meth_ok;
          if (meth_done) begin
            phase_d  = meth_ok ? socks5_hs_pkg::PH_HEAD : socks5_hs_pkg::PH_IDLE;
            cnt_d    = '0;
            hdr_ok_d = 1'b1;
          end
        end
        socks5_hs_pkg::PH_HEAD: begin
          hdr_ok_d = head_ok;
          if (!head_done) begin
            cnt_d = cnt_inc;
          end else if (!hdr_ok_q) begin
            phase_d  = socks5_hs_pkg::PH_IDLE;
            cnt_d    = '0;
            hdr_ok_d = 1'b1;
          end else begin
            case (rx_byte_q)
              socks5_hs_pkg::ATYP_IPV4: begin
                phase_d = socks5_hs_pkg::PH_SKIP;
                cnt_d   = socks5_hs_pkg::SKIP_IPV4;
              end
              socks5_hs_pkg::ATYP_IPV6: begin
                phase_d = socks5_hs_pkg::PH_SKIP;
                cnt_d   = socks5_hs_pkg::SKIP_IPV6;
              end
              socks5_hs_pkg::ATYP_DOMAIN: begin
                phase_d = socks5_hs_pkg::PH_DLEN;
                cnt_d   = '0;
              end
              default: begin
                phase_d  = socks5_hs_pkg::PH_IDLE;
                cnt_d    = '0;
                hdr_ok_d = 1'b1;
              end
            endcase
          end
        end
        socks5_hs_pkg::PH_DLEN: begin
          phase_d = socks5_hs_pkg::PH_SKIP;
          cnt_d   = CW'(rx_byte_q) + socks5_hs_pkg::SKIP_PORT;
        end
        default: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d  = socks5_hs_pkg::PH_IDLE;
            hdr_ok_d = 1'b1;
          end
        end
      endcase
    end
  end

  // outputs: which burst, if any, this item causes
  always_comb begin
    has_burst  = 1'b0;
    burst_kind = socks5_hs_pkg::BURST_FAIL;
    if (is_start) begin
      has_burst  = 1'b1;
      burst_kind = socks5_hs_pkg::BURST_GREET;
    end else if (is_close) begin
      has_burst  = (phase_q != socks5_hs_pkg::PH_IDLE);
    end else if (is_byte) begin
      unique case (phase_q)
        socks5_hs_pkg::PH_METHOD: begin
          has_burst  = meth_done;
          burst_kind = meth_ok ? socks5_hs_pkg::BURST_REQ : socks5_hs_pkg::BURST_FAIL;
        end
        socks5_hs_pkg::PH_HEAD: begin
          if (head_done) begin
            case (rx_byte_q) inside
              socks5_hs_pkg::ATYP_IPV4, socks5_hs_pkg::ATYP_DOMAIN,
              socks5_hs_pkg::ATYP_IPV6: has_burst = !hdr_ok_q;
              default:                  has_burst = 1'b1;
            endcase
          end
        end
        socks5_hs_pkg::PH_DLEN: has_burst = 1'b0;
        default: begin
          has_burst  = (cnt_dec == '0);
          burst_kind = socks5_hs_pkg::BURST_OK;
        end
      endcase
    end
  end

  assign burst_valid_o = in_valid_q && has_burst;
  assign burst_o.kind  = burst_kind;
  assign burst_o.addr  = saved_addr_q;
  assign burst_o.port  = saved_port_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= socks5_hs_pkg::PH_IDLE;
      cnt_q      <= '0;
      hdr_ok_q   <= 1'b1;
    end else begin
      if (req_i.valid && req_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (proc_fire) begin
        in_valid_q <= 1'b0;
      end
      if (proc_fire) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        hdr_ok_q <= hdr_ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_type_q <= req_i.req_type;
      rx_byte_q  <= req_i.rx_byte;
      addr_in_q  <= req_i.target_addr;
      port_in_q  <= req_i.target_port;
    end
    if (proc_fire && is_start) begin
      saved_addr_q <= addr_in_q;
      saved_port_q <= port_in_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/socks5_hs_emit.sv */
`default_nettype none

module socks5_hs_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  socks5_hs_pkg::burst_t burst_i,
  input  logic                  burst_valid_i,
  output logic                  burst_ready_o,
  socks5_hs_res_if.source       res_o
);

  localparam int unsigned IW = socks5_hs_pkg::IDX_W;

  socks5_hs_pkg::burst_t desc_q;
  logic                  desc_valid_q;
  logic [IW-1:0]         idx_q;
  logic                  is_last, fire;

  assign is_last       = (idx_q == socks5_hs_pkg::burst_last_idx(desc_q.kind));
  assign fire          = res_o.valid && res_o.ready;
  assign burst_ready_o = !desc_valid_q || (fire && is_last);

  assign res_o.valid = desc_valid_q;
  assign res_o.last  = is_last;

  always_comb begin
    res_o.out_kind = socks5_hs_pkg::KIND_TX;
    res_o.tx_byte  = 8'h00;
    unique case (desc_q.kind)
      socks5_hs_pkg::BURST_GREET: begin
        case (idx_q)
          IW'(0):  res_o.tx_byte = socks5_hs_pkg::SOCKS_VER;
          IW'(1):  res_o.tx_byte = socks5_hs_pkg::NMETHODS_ONE;
          default: res_o.tx_byte = socks5_hs_pkg::METHOD_NOAUTH;
        endcase
      end
      socks5_hs_pkg::BURST_REQ: begin
        case (idx_q)
          IW'(0):  res_o.tx_byte = socks5_hs_pkg::SOCKS_VER;
          IW'(1):  res_o.tx_byte = socks5_hs_pkg::CMD_CONNECT;
          IW'(2):  res_o.tx_byte = socks5_hs_pkg::RSV_BYTE;
          IW'(3):  res_o.tx_byte = socks5_hs_pkg::ATYP_IPV4;
          IW'(4):  res_o.tx_byte = desc_q.addr[31:24];
          IW'(5):  res_o.tx_byte = desc_q.addr[23:16];
          IW'(6):  res_o.tx_byte = desc_q.addr[15:8];
          IW'(7):  res_o.tx_byte = desc_q.addr[7:0];
          IW'(8):  res_o.tx_byte = desc_q.port[15:8];
          IW'(9):  res_o.tx_byte = desc_q.port[7:0];
          default: res_o.tx_byte = 8'h00;
        endcase
      end
      socks5_hs_pkg::BURST_OK:   res_o.out_kind = socks5_hs_pkg::KIND_OK;
      default:                   res_o.out_kind = socks5_hs_pkg::KIND_FAIL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_valid_q <= 1'b0;
      idx_q        <= '0;
    end else if (burst_valid_i && burst_ready_o) begin
      desc_valid_q <= 1'b1;
      idx_q        <= '0;
    end else if (fire && is_last) begin
      desc_valid_q <= 1'b0;
      idx_q        <= '0;
    end else if (fire) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (burst_valid_i && burst_ready_o) begin
      desc_q <= burst_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/socks5_hs_checker.sv */
`default_nettype none

`include "socks5_connect_handshake_unit_assert.svh"

module socks5_hs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] res_kind_i,
  input logic [7:0] res_tx_i,
  input logic       res_last_i
);

  // stalled result holds
  `S5_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i,
    res_valid_i && $stable(res_kind_i) && $stable(res_tx_i) && $stable(res_last_i))

  // status results stand alone and carry no byte
  `S5_ASSERT_NOW(a_status_alone, res_valid_i && (res_kind_i != socks5_hs_pkg::KIND_TX),
    res_last_i && (res_tx_i == 8'h00))

  // a group that is not finished continues at once with a further byte
  `S5_ASSERT_NEXT(a_group_cont, res_valid_i && res_ready_i && !res_last_i,
    res_valid_i && (res_kind_i == socks5_hs_pkg::KIND_TX))

endmodule

bind socks5_connect_handshake_unit socks5_hs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_kind_i  (res_o.out_kind),
  .res_tx_i    (res_o.tx_byte),
  .res_last_i  (res_o.last)
);

`default_nettype wire

/* tb/tb_socks5_connect_handshake_unit.sv */
`timescale 1ns / 100ps

// Checks the SOCKS5 CONNECT handshake unit, client side, as a black box.
// Stimulus flows from a queue of pending requests into a falling-edge driver.
// A rising-edge monitor runs a local model of the handshake on every accepted
// request and compares each accepted result against the oldest one still due.
module tb_socks5_connect_handshake_unit;
  import socks5_hs_pkg::*;

  // req_type 3 carries no meaning, so the block has to ignore it
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int unsigned STALL_LIMIT = 3000;  // cycles with work but no transaction
  localparam int unsigned TAIL_CYCLES = 20;    // watch for stray results at the end
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rx;
    logic [31:0] addr;
    logic [15:0] port;
  } socks_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } socks_res_t;

  logic clk_i;
  logic rst_ni;

  socks5_hs_req_if req_ch ();
  socks5_hs_res_if res_ch ();

  socks5_connect_handshake_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  // requests waiting to be offered, results the block still owes us
  socks_req_t  outbound_reqs[$];
  socks_res_t  due_results[$];

  int unsigned queued_cnt = 0;  // requests put into outbound_reqs
  int unsigned taken_cnt  = 0;  // requests accepted by the block
  int unsigned made_cnt   = 0;  // requests generated by sessions and directed tests
  int unsigned mism_cnt   = 0;
  int unsigned stall_cnt  = 0;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  // long hold-off: the stimulus bumps hold_ask, the receiver notices and counts
  int unsigned hold_ask  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  logic        req_fired;
  socks_req_t  drv_item;
  socks_req_t  seen_req;
  socks_res_t  mon_got;
  socks_res_t  mon_want;

  // local copy of the handshake state
  phase_e      prx_phase;
  logic [8:0]  prx_cnt;
  logic        prx_hdr_ok;
  logic [31:0] prx_addr;
  logic [15:0] prx_port;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Handshake model
  // ---------------------------------------------------------------------------

  function automatic void emit(logic [1:0] kind, logic [7:0] data, logic last);
    socks_res_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    due_results.push_back(r);
  endfunction

  // end of a handshake, good or bad: one result, back to idle
  function automatic void close_out(logic [1:0] kind);
    prx_phase  = PH_IDLE;
    prx_cnt    = '0;
    prx_hdr_ok = 1'b1;
    emit(kind, 8'h00, 1'b1);
  endfunction

  function automatic void track_handshake(socks_req_t r);
    if (r.kind == REQ_START) begin
      // a start always wins, even over a handshake in progress
      prx_addr   = r.addr;
      prx_port   = r.port;
      prx_phase  = PH_METHOD;
      prx_cnt    = '0;
      prx_hdr_ok = 1'b1;
      emit(KIND_TX, SOCKS_VER, 1'b0);
      emit(KIND_TX, NMETHODS_ONE, 1'b0);
      emit(KIND_TX, METHOD_NOAUTH, 1'b1);
    end else if (r.kind == REQ_CLOSE) begin
      if (prx_phase != PH_IDLE) close_out(KIND_FAIL);
    end else if (r.kind == REQ_BYTE && prx_phase != PH_IDLE) begin
      case (prx_phase)
        PH_METHOD: begin
          // both bytes are taken before the verdict
          if (r.rx != ((prx_cnt == 9'd0) ? SOCKS_VER : METHOD_NOAUTH)) prx_hdr_ok = 1'b0;
          prx_cnt = prx_cnt + 9'd1;
          if (prx_cnt >= 9'd2) begin
            if (!prx_hdr_ok) begin
              close_out(KIND_FAIL);
            end else begin
              prx_phase  = PH_HEAD;
              prx_cnt    = '0;
              prx_hdr_ok = 1'b1;
              emit(KIND_TX, SOCKS_VER, 1'b0);
              emit(KIND_TX, CMD_CONNECT, 1'b0);
              emit(KIND_TX, RSV_BYTE, 1'b0);
              emit(KIND_TX, ATYP_IPV4, 1'b0);
              emit(KIND_TX, prx_addr[31:24], 1'b0);
              emit(KIND_TX, prx_addr[23:16], 1'b0);
              emit(KIND_TX, prx_addr[15:8], 1'b0);
              emit(KIND_TX, prx_addr[7:0], 1'b0);
              emit(KIND_TX, prx_port[15:8], 1'b0);
              emit(KIND_TX, prx_port[7:0], 1'b1);
            end
          end
        end
        PH_HEAD: begin
          // version and reply code checked, reserved byte not
          if (prx_cnt == 9'd0 && r.rx != SOCKS_VER) prx_hdr_ok = 1'b0;
          if (prx_cnt == 9'd1 && r.rx != REP_SUCCESS) prx_hdr_ok = 1'b0;
          if (prx_cnt < 9'd3) begin
            prx_cnt = prx_cnt + 9'd1;
          end else if (!prx_hdr_ok) begin
            close_out(KIND_FAIL);
          end else if (r.rx == ATYP_IPV4) begin
            prx_phase = PH_SKIP;
            prx_cnt   = SKIP_IPV4;
          end else if (r.rx == ATYP_IPV6) begin
            prx_phase = PH_SKIP;
            prx_cnt   = SKIP_IPV6;
          end else if (r.rx == ATYP_DOMAIN) begin
            prx_phase = PH_DLEN;
            prx_cnt   = '0;
          end else begin
            close_out(KIND_FAIL);
          end
        end
        PH_DLEN: begin
          // zero length leaves only the port bytes
          prx_phase = PH_SKIP;
          prx_cnt   = {1'b0, r.rx} + SKIP_PORT;
        end
        default: begin
          if (prx_cnt != 9'd0) prx_cnt = prx_cnt - 9'd1;
          if (prx_cnt == 9'd0) close_out(KIND_OK);
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic socks_req_t mk_req(logic [1:0] kind, logic [7:0] rx,
                                        logic [31:0] addr, logic [15:0] port);
    socks_req_t r;
    r.kind = kind;
    r.rx   = rx;
    r.addr = addr;
    r.port = port;
    return r;
  endfunction

  // unused fields always carry random junk, the block must not care
  function automatic socks_req_t mk_byte(logic [7:0] b);
    return mk_req(REQ_BYTE, b, $urandom, 16'($urandom));
  endfunction

  function automatic socks_req_t mk_ctl(logic [1:0] kind);
    return mk_req(kind, 8'($urandom), $urandom, 16'($urandom));
  endfunction

  task automatic queue_req(socks_req_t r);
    outbound_reqs.push_back(r);
    queued_cnt++;
  endtask

  // One handshake from start to success, then now and again damaged:
  // a wrong header byte, an unknown address type, a close or a restart.
  task automatic queue_session();
    socks_req_t  seq[$];
    socks_req_t  it;
    int unsigned sel;
    int unsigned alen;
    int unsigned mode;
    int unsigned idx;
    logic [7:0]  atyp;
    logic [7:0]  bad;
    bit          damaged;

    seq.push_back(mk_ctl(REQ_START));
    seq.push_back(mk_byte(SOCKS_VER));
    seq.push_back(mk_byte(METHOD_NOAUTH));
    seq.push_back(mk_byte(SOCKS_VER));
    seq.push_back(mk_byte(REP_SUCCESS));
    seq.push_back(mk_byte(8'($urandom)));   // reserved, never checked
    sel = $urandom_range(99);
    if (sel < 30) begin
      atyp = ATYP_IPV4;
      alen = 4;
    end else if (sel < 60) begin
      atyp = ATYP_IPV6;
      alen = 16;
    end else begin
      atyp = ATYP_DOMAIN;
      alen = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(10);
    end
    seq.push_back(mk_byte(atyp));
    if (atyp == ATYP_DOMAIN) seq.push_back(mk_byte(8'(alen)));
    repeat (alen + 2) seq.push_back(mk_byte(8'($urandom)));

    damaged = ($urandom_range(3) == 0);
    mode    = $urandom_range(3);
    idx     = $urandom_range(seq.size() - 1, 1);
    if (damaged && mode == 0) begin
      idx = $urandom_range(6, 1);
      it = seq[idx];
      it.rx = it.rx ^ 8'($urandom_range(255, 1));
      seq[idx] = it;
    end else if (damaged && mode == 1) begin
      do bad = 8'($urandom);
      while (bad == ATYP_IPV4 || bad == ATYP_IPV6 || bad == ATYP_DOMAIN);
      it = seq[6];
      it.rx = bad;
      seq[6] = it;
    end

    for (int unsigned i = 0; i < seq.size(); i++) begin
      if (damaged && mode == 2 && i == idx) begin
        queue_req(mk_ctl(REQ_CLOSE));
        made_cnt++;
        break;
      end
      if (damaged && mode == 3 && i == idx) begin
        queue_req(mk_ctl(REQ_START));
        made_cnt++;
      end
      queue_req(seq[i]);
      made_cnt++;
    end
  endtask

  task automatic fill_until(int unsigned target);
    int unsigned pick;
    while (made_cnt < target) begin
      queue_session();
      // odd requests between sessions: mostly ignored by an idle block
      if ($urandom_range(9) == 0) begin
        pick = $urandom_range(2);
        if (pick == 0) queue_req(mk_byte(8'($urandom)));
        else if (pick == 1) queue_req(mk_ctl(REQ_CLOSE));
        else queue_req(mk_ctl(REQ_UNUSED));
      end
    end
  endtask

  // sender pauses here until every request is in and every result is out
  task automatic drain_all();
    do @(negedge clk_i);
    while (taken_cnt != queued_cnt || due_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hold the offer until the transaction completes, gaps at random
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fired) begin
      if (outbound_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        drv_item = outbound_reqs.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= drv_item.kind;
        req_ch.rx_byte     <= drv_item.rx;
        req_ch.target_addr <= drv_item.addr;
        req_ch.target_port <= drv_item.port;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen    <= hold_ask;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: results checked before the request of the same edge is modelled,
  // so a result can never be matched against an expectation made this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    req_fired <= rst_ni && req_ch.valid && req_ch.ready;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        mon_got.kind = res_ch.out_kind;
        mon_got.data = res_ch.tx_byte;
        mon_got.last = res_ch.last;
        if (due_results.size() == 0) begin
          if (mism_cnt < REPORT_MAX)
            $display("%0t: unexpected result kind %0d byte %02h last %0b",
                     $time, mon_got.kind, mon_got.data, mon_got.last);
          mism_cnt++;
        end else begin
          mon_want = due_results.pop_front();
          if (mon_got.kind !== mon_want.kind || mon_got.data !== mon_want.data ||
              mon_got.last !== mon_want.last) begin
            if (mism_cnt < REPORT_MAX)
              $display("%0t: mismatch, expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                       $time, mon_want.kind, mon_want.data, mon_want.last,
                       mon_got.kind, mon_got.data, mon_got.last);
            mism_cnt++;
          end
        end
      end

      if (req_ch.valid && req_ch.ready) begin
        seen_req.kind = req_ch.req_type;
        seen_req.rx   = req_ch.rx_byte;
        seen_req.addr = req_ch.target_addr;
        seen_req.port = req_ch.target_port;
        track_handshake(seen_req);
        taken_cnt++;
      end

      // watchdog: only counts while something is still owed
      if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready) ||
          (taken_cnt == queued_cnt && due_results.size() == 0)) begin
        stall_cnt = 0;
      end else if (stall_cnt + 1 >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cnt = stall_cnt + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    req_fired          = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_START;
    req_ch.rx_byte     = 8'h00;
    req_ch.target_addr = 32'h0;
    req_ch.target_port = 16'h0;
    res_ch.ready       = 1'b0;

    prx_phase  = PH_IDLE;
    prx_cnt    = '0;
    prx_hdr_ok = 1'b1;
    prx_addr   = '0;
    prx_port   = '0;

    // first phase: sender gaps 20 %, receiver stalls 48 %
    snd_idle_pct = 20;
    rcv_idle_pct = 48;

    // directed: requests that an idle block must ignore
    queue_req(mk_req(REQ_BYTE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
    queue_req(mk_ctl(REQ_CLOSE));
    queue_req(mk_ctl(REQ_UNUSED));
    // all-ones target, IPv6 reply, link lost while skipping the address
    queue_req(mk_req(REQ_START, 8'h00, 32'hFFFF_FFFF, 16'hFFFF));
    queue_req(mk_byte(SOCKS_VER));
    queue_req(mk_byte(METHOD_NOAUTH));
    queue_req(mk_byte(SOCKS_VER));
    queue_req(mk_byte(REP_SUCCESS));
    queue_req(mk_byte(RSV_BYTE));
    queue_req(mk_byte(ATYP_IPV6));
    queue_req(mk_ctl(REQ_CLOSE));
    // all-zero target, restarted half way through the method reply,
    // then the reply offers a method other than no-auth
    queue_req(mk_req(REQ_START, 8'hFF, 32'h0, 16'h0));
    queue_req(mk_byte(SOCKS_VER));
    queue_req(mk_req(REQ_START, 8'hFF, 32'h0, 16'h0));
    queue_req(mk_byte(SOCKS_VER));
    queue_req(mk_byte(NMETHODS_ONE));
    // domain reply with zero length: only the port is skipped
    queue_req(mk_ctl(REQ_START));
    queue_req(mk_byte(SOCKS_VER));
    queue_req(mk_byte(METHOD_NOAUTH));
    queue_req(mk_byte(SOCKS_VER));
    queue_req(mk_byte(REP_SUCCESS));
    queue_req(mk_byte(RSV_BYTE));
    queue_req(mk_byte(ATYP_DOMAIN));
    queue_req(mk_byte(8'h00));
    queue_req(mk_byte(8'h00));
    queue_req(mk_byte(8'hFF));
    made_cnt = 26;

    fill_until(150);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    drain_all();

    // second phase: roles swapped
    @(posedge clk_i);
    snd_idle_pct = 48;
    rcv_idle_pct = 20;
    fill_until(310);
    drain_all();

    // last phase: no idling, and one long receiver hold-off at its start so
    // that the block backs up and holds off the sender
    @(posedge clk_i);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_ask++;
    fill_until(470);
    drain_all();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mism_cnt == 0 && due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
